[hw/rtl/led_ring_point_animator_core_macros.svh]
// Assertion macros used by the checker file of the LED ring point animator.
// Depends on nothing; include it by its bare file name.
`ifndef LED_RING_POINT_ANIMATOR_CORE_MACROS_SVH
`define LED_RING_POINT_ANIMATOR_CORE_MACROS_SVH

// Full form: label, clock, active-low reset, property, message.
`define LRPA_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Short form on the block's own clock and reset.
`define LRPA_ASSERT(lbl, prop, msg) \
  `LRPA_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[hw/rtl/lrpa_pkg.sv]
// Package of the LED ring point animator: sizes, constants, word types and helpers.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps

package lrpa_pkg;

  localparam int NUM_LEDS       = 18;
  localparam int NUM_POINTS     = 5;
  localparam int FRAC_BITS      = 12;
  localparam int NUM_COLOR_REGS = 5;

  localparam int LED_W     = 5;
  localparam int PT_W      = 3;
  localparam int CFG_IDX_W = 3;
  localparam int COLOR_W   = 24;
  localparam int POS_W     = 17;
  localparam int VEL_W     = 12;
  localparam int ACC_W     = 11;
  localparam int DIV_W     = 16;
  localparam int DIV_CNT_W = 4;
  localparam int D_W       = FRAC_BITS + 2;
  localparam int PROD_W    = 8 + D_W;

  localparam int ONE_LED    = 1 << FRAC_BITS;
  localparam int RADIUS     = 3 << FRAC_BITS;
  localparam int RING_LEN   = NUM_LEDS << FRAC_BITS;
  localparam int VEL_MAX    = ONE_LED / 3;
  localparam int TIME_SCALE = 45;
  localparam int SPAN       = 7;
  localparam int SPAN_W     = 3;
  // Division by three of a value below 1024: multiply by 683, shift by 11.
  localparam int RECIP3     = 683;
  localparam int RECIP_SH   = 11;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_ON   = 2'd1;
  localparam logic [1:0] MODE_SPIN = 2'd2;
  localparam logic [1:0] MODE_BAD  = 2'd3;

  localparam logic [COLOR_W-1:0] COLOR_RST [NUM_COLOR_REGS] =
    '{24'hFFFFFF, 24'hFFFF00, 24'h00FF00, 24'h0000FF, 24'h00FFDD};

  typedef struct packed {
    logic [1:0]        mode;
    logic [15:0]       dt_ms;
    logic signed [7:0] accel_0;
    logic signed [7:0] accel_1;
    logic signed [7:0] accel_2;
    logic signed [7:0] accel_3;
    logic signed [7:0] accel_4;
  } in_word_t;

  typedef struct packed {
    logic [LED_W-1:0] led_index;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             frame_last;
  } out_word_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

  // Reset position of point i: i * ring length / number of points.
  function automatic logic [POS_W-1:0] pos_rst(input int i);
    int v;
    v = ((i * NUM_LEDS) << FRAC_BITS) / NUM_POINTS;
    return POS_W'(v);
  endfunction

  // Acceleration of point i; point i uses input i mod 5.
  function automatic logic signed [7:0] accel_of(input in_word_t w,
                                                 input logic [PT_W-1:0] i);
    logic signed [7:0] a;
    unique case (i)
      3'd1:    a = w.accel_1;
      3'd2:    a = w.accel_2;
      3'd3:    a = w.accel_3;
      3'd4:    a = w.accel_4;
      3'd5:    a = w.accel_0;
      3'd6:    a = w.accel_1;
      3'd7:    a = w.accel_2;
      default: a = w.accel_0;
    endcase
    return a;
  endfunction

  function automatic logic [7:0] sat8(input logic [ACC_W-1:0] v);
    return (|v[ACC_W-1:8]) ? 8'hFF : v[7:0];
  endfunction

endpackage

[hw/rtl/lrpa_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lrpa_pkg for the request and response types.
`timescale 1ns / 1ps

module lrpa_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lrpa_pkg::div_req_t req_i,
  output lrpa_pkg::div_rsp_t rsp_o
);
  import lrpa_pkg::*;

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     quo_q, den_q;
  logic [DIV_W:0]       rem_q;
  logic [DIV_W:0]       rem_sh;
  logic [DIV_W+1:0]     diff;

  assign rem_sh = {rem_q[DIV_W-1:0], quo_q[DIV_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      if (!diff[DIV_W+1]) begin
        rem_q <= diff[DIV_W:0];
        quo_q <= {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

[hw/rtl/led_ring_point_animator_core.sv]
// Top level of the LED ring point animator: sequencer, point state and pixel memory.
// Depends on lrpa_pkg and the divider lrpa_div.
`timescale 1ns / 1ps

//  channel | signals                              | moves
//  --------+--------------------------------------+-------------------------------
//  cfg     | cfg_we_i, cfg_index_i, cfg_wdata_i   | one color register per write
//  in      | in_valid_i, in_ready_o, in_data_i    | one tick word (mode, dt, accels)
//  out     | out_valid_o, out_ready_i, out_data_o | one pixel word, 18 per frame
//
// A mode change reads each pixel from the memory, then loads it into the output word.
// A spin tick runs two 16-bit divisions per point in the divider, clears the pixel
// memory, walks 7 ring positions per point (geometry, then memory read, two products
// and write back for those in reach), then sends the frame.
// After reset the block clears the pixel memory and renders the reset points, and holds
// in_ready_o low meanwhile. A stalled output word holds the frame sequencer.

module led_ring_point_animator_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lrpa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lrpa_pkg::COLOR_W-1:0]       cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  lrpa_pkg::in_word_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output lrpa_pkg::out_word_t                out_data_o
);
  import lrpa_pkg::*;

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_WALK = 13'b0000000000010,
    ST_DV   = 13'b0000000000100,
    ST_DP   = 13'b0000000001000,
    ST_CLR  = 13'b0000000010000,
    ST_R0   = 13'b0000000100000,
    ST_R1   = 13'b0000001000000,
    ST_R2   = 13'b0000010000000,
    ST_R3   = 13'b0000100000000,
    ST_R4   = 13'b0001000000000,
    ST_ERD  = 13'b0010000000000,
    ST_ELD  = 13'b0100000000000,
    ST_EXX  = 13'b1000000000000
  } state_e;

  localparam logic signed [POS_W+1:0] RING_S = (POS_W+2)'(RING_LEN);
  localparam logic signed [13:0]      VMAX_S = 14'(VEL_MAX);

  // Control state.
  state_e            state_q, state_d;
  logic              init_q, init_d;
  logic [PT_W-1:0]   pt_q, pt_d;
  logic [SPAN_W-1:0] j_q, j_d;
  logic [LED_W-1:0]  eidx_q, eidx_d;
  logic [1:0]        prev_mode_q, prev_mode_d;
  logic              black_q, black_d;
  logic              out_valid_q, out_valid_d;

  logic [COLOR_W-1:0]      color_q [NUM_COLOR_REGS];
  logic signed [VEL_W-1:0] vel_q [NUM_POINTS];
  logic [POS_W-1:0]        pos_q [NUM_POINTS];

  // Data path registers.
  in_word_t              in_q;
  logic [D_W-1:0]        d_q;
  logic [LED_W-1:0]      led_q;
  logic                  ok_q;
  logic [PROD_W-1:0]     prod_q [3];
  logic [7:0]            c1_q [3];
  logic [3*ACC_W-1:0]    rd_q;
  out_word_t             out_q;
  logic [3*ACC_W-1:0]    mem [NUM_LEDS];

  // Strobes.
  logic in_ld, vel_we, pos_we, geo_ld, prod_ld, c1_ld, prod2_ld, out_ld;
  logic mem_we, mem_re;
  logic [LED_W-1:0]   mem_waddr, mem_raddr;
  logic [3*ACC_W-1:0] mem_wdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  lrpa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Walk arithmetic: velocity and position updates of point pt_q.
  logic [15:0]             dt_eff;
  logic signed [7:0]       acc;
  logic [7:0]              acc_mag;
  logic [DIV_W-1:0]        a_num, v_num;
  logic signed [13:0]      sdv, vsum;
  logic signed [VEL_W-1:0] vclamp, vneg;
  logic [10:0]             vmag;
  logic signed [POS_W:0]   sdp;
  logic signed [POS_W+1:0] psum;
  logic [POS_W-1:0]        pos_new;

  always_comb begin
    dt_eff  = (in_q.dt_ms == 16'd0) ? 16'd1 : in_q.dt_ms;
    acc     = accel_of(in_q, pt_q);
    acc_mag = acc[7] ? 8'(-acc) : acc;
    a_num   = {8'b0, acc_mag} * 16'(TIME_SCALE);
    sdv     = acc[7] ? -$signed({1'b0, div_rsp.quo[12:0]}) : $signed({1'b0, div_rsp.quo[12:0]});
    vsum    = $signed({{(14-VEL_W){vel_q[pt_q][VEL_W-1]}}, vel_q[pt_q]}) + sdv;
    if (vsum > VMAX_S) begin
      vclamp = VEL_W'(VMAX_S);
    end else if (vsum < -VMAX_S) begin
      vclamp = VEL_W'(-VMAX_S);
    end else begin
      vclamp = vsum[VEL_W-1:0];
    end
    vneg  = -vclamp;
    vmag  = vclamp[VEL_W-1] ? vneg[10:0] : vclamp[10:0];
    v_num = {5'b0, vmag} * 16'(TIME_SCALE);
    // The velocity was already updated, so its sign sets the direction.
    sdp   = vel_q[pt_q][VEL_W-1] ? -$signed({2'b0, div_rsp.quo})
                                 : $signed({2'b0, div_rsp.quo});
    psum  = $signed({2'b0, pos_q[pt_q]}) + $signed({sdp[POS_W], sdp});
    if (psum < 0) begin
      psum = psum + RING_S;
    end else if (psum > RING_S) begin
      psum = psum - RING_S;
    end
    pos_new = psum[POS_W-1:0];
  end

  // Render geometry of ring position j_q around point pt_q.
  logic [POS_W-1:0]          gp;
  logic signed [3:0]         jm3;
  logic signed [FRAC_BITS+3:0] gdiff, gdist, gd;
  logic signed [6:0]         li;
  logic [COLOR_W-1:0]        col;

  always_comb begin
    gp    = pos_q[pt_q];
    jm3   = $signed({1'b0, j_q}) - 4'sd3;
    gdiff = $signed({jm3, {FRAC_BITS{1'b0}}}) - $signed({4'b0, gp[FRAC_BITS-1:0]});
    gdist = gdiff[FRAC_BITS+3] ? -gdiff : gdiff;
    gd    = (FRAC_BITS+4)'(RADIUS) - gdist;
    li    = $signed({2'b0, gp[POS_W-1:FRAC_BITS]}) + $signed({4'b0, j_q}) - 7'sd3;
    if (li < 0) begin
      li = li + 7'(NUM_LEDS);
    end else if (li >= 7'(NUM_LEDS)) begin
      li = li - 7'(NUM_LEDS);
    end
    col = init_q ? COLOR_RST[pt_q] : color_q[pt_q];
  end

  // Channel weight: c * (d / R) squared, each step computed as ((x * d) >> FRAC_BITS) / 3.
  logic [7:0]          c2 [3];
  logic [3*ACC_W-1:0]  sum_row;
  logic [9:0]          q1 [3];
  logic [9:0]          q2 [3];
  logic [19:0]         r1 [3];
  logic [19:0]         r2 [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      q1[ch] = prod_q[ch][PROD_W-1:FRAC_BITS];
      r1[ch] = {10'b0, q1[ch]} * 20'(RECIP3);
      q2[ch] = prod_q[ch][PROD_W-1:FRAC_BITS];
      r2[ch] = {10'b0, q2[ch]} * 20'(RECIP3);
      c2[ch] = 8'(r2[ch] >> RECIP_SH);
      sum_row[(2-ch)*ACC_W +: ACC_W] = rd_q[(2-ch)*ACC_W +: ACC_W] + {3'b0, c2[ch]};
    end
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    init_d      = init_q;
    pt_d        = pt_q;
    j_d         = j_q;
    eidx_d      = eidx_q;
    prev_mode_d = prev_mode_q;
    black_d     = black_q;
    in_ld       = 1'b0;
    vel_we      = 1'b0;
    pos_we      = 1'b0;
    geo_ld      = 1'b0;
    prod_ld     = 1'b0;
    c1_ld       = 1'b0;
    prod2_ld    = 1'b0;
    out_ld      = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = eidx_q;
    mem_raddr   = eidx_q;
    mem_wdata   = '0;
    div_req     = '0;
    div_req.den = dt_eff;
    div_req.num = a_num;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          priority if (in_data_i.mode == MODE_BAD) begin
            state_d = ST_IDLE;
          end else if (in_data_i.mode != prev_mode_q) begin
            prev_mode_d = in_data_i.mode;
            black_d     = (in_data_i.mode == MODE_OFF);
            eidx_d      = '0;
            state_d     = ST_ERD;
          end else if (in_data_i.mode == MODE_SPIN) begin
            in_ld   = 1'b1;
            pt_d    = '0;
            state_d = ST_WALK;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_WALK: begin
        div_req.start = 1'b1;
        state_d       = ST_DV;
      end
      ST_DV: begin
        if (div_rsp.done) begin
          vel_we        = 1'b1;
          div_req.start = 1'b1;
          div_req.num   = v_num;
          state_d       = ST_DP;
        end
      end
      ST_DP: begin
        if (div_rsp.done) begin
          pos_we = 1'b1;
          if (pt_q == PT_W'(NUM_POINTS - 1)) begin
            pt_d    = '0;
            eidx_d  = '0;
            state_d = ST_CLR;
          end else begin
            pt_d    = pt_q + 1'b1;
            state_d = ST_WALK;
          end
        end
      end
      ST_CLR: begin
        mem_we = 1'b1;
        if (eidx_q == LED_W'(NUM_LEDS - 1)) begin
          eidx_d  = '0;
          pt_d    = '0;
          j_d     = '0;
          state_d = ST_R0;
        end else begin
          eidx_d = eidx_q + 1'b1;
        end
      end
      ST_R0: begin
        geo_ld  = 1'b1;
        state_d = ST_R1;
      end
      ST_R1, ST_R4: begin
        if (state_q == ST_R1 && ok_q) begin
          mem_re    = 1'b1;
          mem_raddr = led_q;
          prod_ld   = 1'b1;
          state_d   = ST_R2;
        end else begin
          if (state_q == ST_R4) begin
            mem_we    = 1'b1;
            mem_waddr = led_q;
            mem_wdata = sum_row;
          end
          if (j_q == SPAN_W'(SPAN - 1)) begin
            j_d = '0;
            if (pt_q == PT_W'(NUM_POINTS - 1)) begin
              pt_d   = '0;
              eidx_d = '0;
              init_d = 1'b0;
              state_d = init_q ? ST_IDLE : ST_ERD;
            end else begin
              pt_d    = pt_q + 1'b1;
              state_d = ST_R0;
            end
          end else begin
            j_d     = j_q + 1'b1;
            state_d = ST_R0;
          end
        end
      end
      ST_R2: begin
        c1_ld   = 1'b1;
        state_d = ST_R3;
      end
      ST_R3: begin
        prod2_ld = 1'b1;
        state_d  = ST_R4;
      end
      ST_ERD: begin
        mem_re  = 1'b1;
        state_d = ST_ELD;
      end
      ST_ELD: begin
        if (!out_valid_q || out_ready_i) begin
          out_ld = 1'b1;
          if (eidx_q == LED_W'(NUM_LEDS - 1)) begin
            state_d = ST_IDLE;
          end else begin
            eidx_d  = eidx_q + 1'b1;
            state_d = ST_ERD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (out_ld) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control and point state. Reset starts with a render of the reset points.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      init_q      <= 1'b1;
      pt_q        <= '0;
      j_q         <= '0;
      eidx_q      <= '0;
      prev_mode_q <= MODE_ON;
      black_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_COLOR_REGS; i++) begin
        color_q[i] <= COLOR_RST[i];
      end
      for (int i = 0; i < NUM_POINTS; i++) begin
        vel_q[i] <= '0;
        pos_q[i] <= pos_rst(i);
      end
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      pt_q        <= pt_d;
      j_q         <= j_d;
      eidx_q      <= eidx_d;
      prev_mode_q <= prev_mode_d;
      black_q     <= black_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (cfg_index_i < CFG_IDX_W'(NUM_COLOR_REGS))) begin
        color_q[cfg_index_i] <= cfg_wdata_i;
      end
      if (vel_we) begin
        vel_q[pt_q] <= vclamp;
      end
      if (pos_we) begin
        pos_q[pt_q] <= pos_new;
      end
    end
  end

  // Data path registers; at most one multiplication between any two of them.
  always_ff @(posedge clk_i) begin
    if (in_ld) begin
      in_q <= in_data_i;
    end
    if (geo_ld) begin
      d_q   <= gd[D_W-1:0];
      led_q <= li[LED_W-1:0];
      ok_q  <= (gd > 0);
    end
    for (int ch = 0; ch < 3; ch++) begin
      if (prod_ld) begin
        prod_q[ch] <= col[(2-ch)*8 +: 8] * d_q;
      end
      if (c1_ld) begin
        c1_q[ch] <= 8'(r1[ch] >> RECIP_SH);
      end
      if (prod2_ld) begin
        prod_q[ch] <= c1_q[ch] * d_q;
      end
    end
    if (out_ld) begin
      out_q.led_index  <= eidx_q;
      out_q.red        <= black_q ? 8'h00 : sat8(rd_q[2*ACC_W +: ACC_W]);
      out_q.green      <= black_q ? 8'h00 : sat8(rd_q[ACC_W +: ACC_W]);
      out_q.blue       <= black_q ? 8'h00 : sat8(rd_q[0 +: ACC_W]);
      out_q.frame_last <= (eidx_q == LED_W'(NUM_LEDS - 1));
    end
  end

  // Pixel memory: three channel sums per LED, registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hw/rtl/lrpa_checker.sv]
// Port checker of the LED ring point animator and its bind to the top level.
// Depends on lrpa_pkg and led_ring_point_animator_core_macros.svh.
`timescale 1ns / 1ps
`include "led_ring_point_animator_core_macros.svh"

module lrpa_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input lrpa_pkg::out_word_t out_data_o
);
  import lrpa_pkg::*;

  `LRPA_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "output word dropped")
  `LRPA_ASSERT(a_index_range, out_valid_o |-> out_data_o.led_index < LED_W'(NUM_LEDS), "bad index")
  `LRPA_ASSERT(a_last_flag, out_valid_o |-> (out_data_o.frame_last == (out_data_o.led_index == LED_W'(NUM_LEDS - 1))), "frame_last off")
  `LRPA_ASSERT(a_busy_in_frame, out_valid_o && !out_data_o.frame_last |-> !in_ready_o, "ready mid-frame")

endmodule

bind led_ring_point_animator_core lrpa_checker u_lrpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
